### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers with synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert with explicit clock and reset
`define BPS_ASSERT_CR(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) else $error(msg);

// assert on clk / rst_n
`define BPS_ASSERT(lbl, prop, msg) \
  `BPS_ASSERT_CR(lbl, clk, rst_n, prop, msg)

`endif

### rtl/core/bps_pkg.sv
// ---------------------------------------------------------------------------
// bps_pkg
// Types and constants shared by the burner pre-purge supervisor modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bps_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_MIN_PURGE   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_TIMEOUT     = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_RAMP        = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SPEED_BAND  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_STABLE      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_FLAME_FAULT = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_BASE_SPEED  = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_BLOCKED     = 3'd7;

  // reset values
  localparam logic [15:0] RST_MIN_PURGE   = 16'd150;
  localparam logic [15:0] RST_TIMEOUT     = 16'd800;
  localparam logic [15:0] RST_RAMP        = 16'd600;
  localparam logic [15:0] RST_SPEED_BAND  = 16'd100;
  localparam logic [7:0]  RST_STABLE      = 8'd50;
  localparam logic [15:0] RST_FLAME_FAULT = 16'd100;

  // next_state codes
  localparam logic [1:0] NS_STAY   = 2'd0;
  localparam logic [1:0] NS_IGNITE = 2'd1;
  localparam logic [1:0] NS_END    = 2'd2;
  localparam logic [1:0] NS_IDLE   = 2'd3;

  // error_kind codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_STOPPED = 3'd1;
  localparam logic [2:0] ERR_BLOCKED = 3'd2;
  localparam logic [2:0] ERR_FLAME   = 3'd3;
  localparam logic [2:0] ERR_HEAT    = 3'd4;
  localparam logic [2:0] ERR_SENSOR  = 3'd5;

  typedef struct packed {
    logic [15:0] min_purge;
    logic [15:0] timeout;
    logic [15:0] ramp;
    logic [15:0] speed_band;
    logic [7:0]  stable;
    logic [15:0] flame_fault;
    logic [15:0] base_speed;
    logic [15:0] blocked;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic        fan_running;
    logic [15:0] fan_speed;
    logic        flame_seen;
    logic        burn_enable;
    logic        water_flow;
    logic        overheat_switch;
    logic        valve_fault;
    logic [7:0]  sensor_fault_code;
  } item_t;

  typedef struct packed {
    logic [1:0]  next_state;
    logic [2:0]  error_kind;
    logic [7:0]  sensor_code;
    logic        fan_force_off;
    logic [15:0] blocked_threshold;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIVLD,
    ST_DIV,
    ST_DONE
  } bps_state_t;

endpackage

### rtl/core/bps_div.sv
// ---------------------------------------------------------------------------
// bps_div
// Restoring divider, one quotient bit per cycle, 32/16 with 16-bit quotient.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,   // upper half must be below divisor
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[15]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_nxt = ge ? 16'(rem_sh - {1'b0, divisor}) : rem_sh[15:0];
    quo_nxt = {quo_r[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'hF) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[31:16];
      quo_r <= dividend[15:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/bps_dp.sv
// ---------------------------------------------------------------------------
// bps_dp
// Datapath: item capture, supervision state, fault decisions, ramp divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bps_dp import bps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output result_t res
);

  item_t       it_r;
  logic [15:0] tick_r, last_r, flame_r;
  logic [7:0]  stab_r;
  logic [1:0]  nxt_r;
  logic [2:0]  err_r;
  logic [7:0]  scode_r;
  logic        force_r, ramp_r, ign_r;
  logic [15:0] diff_r, el_r;
  logic [31:0] prod_r;
  result_t     res_r;

  logic [15:0] tick_nxt, last_nxt, flame_nxt, el_raw, el_nxt, diff_nxt;
  logic [7:0]  stab_nxt;
  logic [16:0] last_hi, speed_hi;
  logic        in_band, timeout, ramp_on, flame_flt, ign_ok;
  logic [1:0]  ev_nxt;
  logic [2:0]  ev_err;
  logic [7:0]  ev_scode;
  logic        ev_force;
  logic [15:0] quo, thr_sum;
  logic        div_done;

  bps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (cfg.ramp),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    last_hi  = {1'b0, last_r} + {1'b0, cfg.speed_band};
    speed_hi = {1'b0, it_r.fan_speed} + {1'b0, cfg.speed_band};
    in_band  = (last_hi >= {1'b0, it_r.fan_speed}) && ({1'b0, last_r} <= speed_hi);
    if (it_r.fan_running) begin
      if (!in_band || (tick_r <= {8'd0, cfg.stable})) begin
        stab_nxt = '0;
      end else if (stab_r != 8'hFF) begin
        stab_nxt = stab_r + 8'd1;
      end else begin
        stab_nxt = stab_r;
      end
      last_nxt = it_r.fan_speed;
    end else begin
      stab_nxt = '0;
      last_nxt = '0;
    end

    tick_nxt = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;
    timeout  = tick_nxt > cfg.timeout;
    ramp_on  = !timeout && (tick_nxt >= cfg.min_purge);
    el_raw   = tick_nxt - cfg.min_purge;
    el_nxt   = (el_raw > cfg.ramp) ? cfg.ramp : el_raw;
    diff_nxt = cfg.blocked - cfg.base_speed;

    if (it_r.flame_seen) begin
      flame_nxt = (flame_r != 16'hFFFF) ? flame_r + 16'd1 : flame_r;
    end else begin
      flame_nxt = '0;
    end
    flame_flt = flame_nxt >= cfg.flame_fault;

    ev_nxt   = NS_STAY;
    ev_err   = ERR_NONE;
    ev_scode = '0;
    ev_force = 1'b0;
    if (timeout && !it_r.flame_seen) begin
      ev_err   = it_r.fan_running ? ERR_BLOCKED : ERR_STOPPED;
      ev_force = !it_r.fan_running;
      ev_nxt   = NS_END;
    end
    if (!it_r.burn_enable || !it_r.water_flow) begin
      ev_nxt = NS_IDLE;
    end
    if (flame_flt) begin
      ev_err = ERR_FLAME;
      ev_nxt = NS_END;
    end
    if (it_r.overheat_switch || it_r.valve_fault) begin
      ev_err = ERR_HEAT;
      ev_nxt = NS_END;
    end
    if (it_r.sensor_fault_code != 8'd0) begin
      ev_err   = ERR_SENSOR;
      ev_scode = it_r.sensor_fault_code;
      ev_nxt   = NS_END;
    end

    ign_ok = ramp_on && it_r.fan_running && (stab_nxt > cfg.stable)
          && it_r.burn_enable && it_r.water_flow && !flame_flt
          && !it_r.overheat_switch && !it_r.valve_fault
          && (it_r.sensor_fault_code == 8'd0);
  end

  always_comb begin
    thr_sum = ((cfg.ramp == 16'd0) ? diff_r : quo) + cfg.base_speed;
  end

  // supervision state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      last_r  <= '0;
      stab_r  <= '0;
      flame_r <= '0;
    end else if (cmd.eval) begin
      if (it_r.cmd) begin
        tick_r <= '0;
      end else begin
        tick_r  <= tick_nxt;
        last_r  <= last_nxt;
        stab_r  <= stab_nxt;
        flame_r <= flame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= 1'b0;
    end else if (cmd.eval) begin
      ramp_r <= !it_r.cmd && ramp_on;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= item;
    end
    if (cmd.eval) begin
      if (it_r.cmd) begin
        nxt_r   <= NS_STAY;
        err_r   <= ERR_NONE;
        scode_r <= '0;
        force_r <= 1'b0;
        ign_r   <= 1'b0;
      end else begin
        nxt_r   <= ev_nxt;
        err_r   <= ev_err;
        scode_r <= ev_scode;
        force_r <= ev_force;
        ign_r   <= ign_ok;
      end
      diff_r <= diff_nxt;
      el_r   <= el_nxt;
    end
    if (cmd.mul) begin
      prod_r <= {16'd0, diff_r} * {16'd0, el_r};
    end
    if (cmd.out_load) begin
      res_r.next_state        <= (ign_r && (it_r.fan_speed < thr_sum)) ? NS_IGNITE : nxt_r;
      res_r.error_kind        <= err_r;
      res_r.sensor_code       <= scode_r;
      res_r.fan_force_off     <= force_r;
      res_r.blocked_threshold <= ramp_r ? thr_sum : 16'd0;
    end
  end

  assign sts.need_div = ramp_r && (cfg.ramp != 16'd0);
  assign sts.div_done = div_done;
  assign res          = res_r;

endmodule

### rtl/core/bps_ctrl.sv
// ---------------------------------------------------------------------------
// bps_ctrl
// Controller: sequences capture, evaluation, ramp divide and result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bps_ctrl import bps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  bps_state_t state_r, state_nxt;
  logic       oval_r, oval_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    oval_nxt  = out_tready ? 1'b0 : oval_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // skip the divide when no ramp is computed or ramp length is zero
        cmd.mul   = 1'b1;
        state_nxt = sts.need_div ? ST_DIVLD : ST_DONE;
      end
      ST_DIVLD: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!oval_r || out_tready) begin
          cmd.out_load = 1'b1;
          oval_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = oval_r;

endmodule

### rtl/core/burner_prepurge_supervisor.sv
// ---------------------------------------------------------------------------
// burner_prepurge_supervisor
// Pre-purge fan phase supervisor: one input transaction per 10 ms tick or
// state entry, one result transaction per input transaction.
// Input stream (in_*): tuser carries cmd (0 tick, 1 enter); tdata carries the
// fan, flame, enable, water, overheat, valve and sensor fields.
// Result stream (out_*): next state, error kind, sensor code, fan force-off
// and the ramped blocked-speed threshold.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr.
// An enter item, or a tick outside the ramp window, passes the evaluate, multiply
// and done states; a tick inside the ramp window with a nonzero ramp length also
// passes the divider load and divide states of the 16-step restoring divider.
// One item is processed at a time; in_tready is high only while idle, so a new
// item is taken only once the previous result has moved to the output register.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, the following result holds in the block
// until the output register frees, and input is blocked meanwhile.
// Reset clears the tick, stability and flame counters and loads the default
// configuration values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module burner_prepurge_supervisor import bps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // fan_running, fan_speed, flame_seen, burn_enable, water_flow,
  // overheat_switch, valve_fault, sensor_fault_code
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // next_state, error_kind, sensor_code, fan_force_off, blocked_threshold
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  cfg_t    cfg_r;
  item_t   item;
  result_t res;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_purge   <= RST_MIN_PURGE;
      cfg_r.timeout     <= RST_TIMEOUT;
      cfg_r.ramp        <= RST_RAMP;
      cfg_r.speed_band  <= RST_SPEED_BAND;
      cfg_r.stable      <= RST_STABLE;
      cfg_r.flame_fault <= RST_FLAME_FAULT;
      cfg_r.base_speed  <= '0;
      cfg_r.blocked     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_PURGE:   cfg_r.min_purge   <= cfg_wdata;
        CFG_TIMEOUT:     cfg_r.timeout     <= cfg_wdata;
        CFG_RAMP:        cfg_r.ramp        <= cfg_wdata;
        CFG_SPEED_BAND:  cfg_r.speed_band  <= cfg_wdata;
        CFG_STABLE:      cfg_r.stable      <= cfg_wdata[7:0];
        CFG_FLAME_FAULT: cfg_r.flame_fault <= cfg_wdata;
        CFG_BASE_SPEED:  cfg_r.base_speed  <= cfg_wdata;
        CFG_BLOCKED:     cfg_r.blocked     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.cmd               = in_tuser;
    item.fan_running       = in_tdata[0];
    item.fan_speed         = in_tdata[16:1];
    item.flame_seen        = in_tdata[17];
    item.burn_enable       = in_tdata[18];
    item.water_flow        = in_tdata[19];
    item.overheat_switch   = in_tdata[20];
    item.valve_fault       = in_tdata[21];
    item.sensor_fault_code = in_tdata[29:22];
  end

  assign out_tdata = {2'b00, res.blocked_threshold, res.fan_force_off,
                      res.sensor_code, res.error_kind, res.next_state};

  bps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bps_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item),
    .cmd   (cmd),
    .sts   (sts),
    .res   (res)
  );

  `BPS_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "accepted while busy")
  `BPS_ASSERT(a_err_range, out_tvalid |-> (out_tdata[4:2] <= ERR_SENSOR), "error kind out of range")
  `BPS_ASSERT(a_scode_only_sensor, (out_tvalid && (out_tdata[4:2] != ERR_SENSOR)) |-> (out_tdata[12:5] == 8'd0), "sensor code without sensor error")
  `BPS_ASSERT(a_force_ends_purge, (out_tvalid && out_tdata[13]) |-> out_tdata[1], "fan force-off while staying")
  `BPS_ASSERT(a_ignite_clean, (out_tvalid && (out_tdata[1:0] == NS_IGNITE)) |-> (out_tdata[4:2] == ERR_NONE), "ignition with error")

endmodule

### tb/tb_burner_prepurge_supervisor.sv
// ---------------------------------------------------------------------------
// tb_burner_prepurge_supervisor
// Self-checking bench for the pre-purge supervisor. A directed table covers
// reset values, overrides, zero ramp, zero flame-fault count and timeout;
// then random phases under several register settings feed purge sequences
// (enter, then ticks with a wandering fan speed) mixed with noise. Every
// result transaction is compared against its table entry or the in-bench predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_burner_prepurge_supervisor;
  import bps_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 25;
  localparam int NPHASE = 7;
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_ENTER = 1'b1;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [15:0] wdata;
    item_t       it;
    result_t     res;
  } drow_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // fan_running, fan_speed, flame_seen, burn_enable, water_flow,
  // overheat_switch, valve_fault, sensor_fault_code
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // cmd
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // next_state, error_kind, sensor_code, fan_force_off, blocked_threshold
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  burner_prepurge_supervisor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  cfg_t        cfg_now;
  int unsigned tick_cnt = 0;
  int unsigned prev_speed = 0;
  int unsigned stab_cnt = 0;
  int unsigned flame_cnt = 0;
  result_t     verdict_q[$];
  int unsigned bad_count = 0;
  int unsigned seen_count = 0;
  int unsigned cyc = 0;
  bit          valid_held = 0;
  int          burst_left = 0;
  int          walk_spd = 0;
  int          rcv_mode = 0;
  int          rcv_tick = 0;
  int          rcv_hold = 0;

  function automatic result_t purge_judge(item_t it);
    result_t     r;
    int unsigned spd, band, diff, el, scaled;
    bit          in_band;
    r = '0;
    if (it.cmd == CMD_ENTER) begin
      tick_cnt = 0;
      return r;
    end
    spd  = it.fan_speed;
    band = cfg_now.speed_band;
    if (it.fan_running) begin
      in_band = (prev_speed + band >= spd) && (prev_speed <= spd + band);
      if (!in_band || tick_cnt <= cfg_now.stable) stab_cnt = 0;
      else if (stab_cnt < 255) stab_cnt++;
      prev_speed = spd;
    end else begin
      prev_speed = 0;
      stab_cnt = 0;
    end
    if (tick_cnt < 16'hFFFF) tick_cnt++;
    if (tick_cnt > cfg_now.timeout) begin
      if (!it.flame_seen) begin
        r.error_kind    = it.fan_running ? ERR_BLOCKED : ERR_STOPPED;
        r.fan_force_off = !it.fan_running;
        r.next_state    = NS_END;
      end
    end else if (tick_cnt >= cfg_now.min_purge) begin
      diff = (cfg_now.blocked - cfg_now.base_speed) & 32'hFFFF;
      if (cfg_now.ramp == 0) begin
        scaled = diff;
      end else begin
        el = tick_cnt - cfg_now.min_purge;
        if (el > cfg_now.ramp) el = cfg_now.ramp;
        scaled = (diff * el) / cfg_now.ramp;
      end
      r.blocked_threshold = 16'(scaled + cfg_now.base_speed);
      if (it.fan_running && stab_cnt > cfg_now.stable && spd < r.blocked_threshold)
        r.next_state = NS_IGNITE;
    end
    if (!it.burn_enable || !it.water_flow) r.next_state = NS_IDLE;
    if (it.flame_seen) begin
      if (flame_cnt < 16'hFFFF) flame_cnt++;
    end else begin
      flame_cnt = 0;
    end
    if (flame_cnt >= cfg_now.flame_fault) begin
      r.error_kind = ERR_FLAME;
      r.next_state = NS_END;
    end
    if (it.overheat_switch || it.valve_fault) begin
      r.error_kind = ERR_HEAT;
      r.next_state = NS_END;
    end
    if (it.sensor_fault_code != 0) begin
      r.error_kind  = ERR_SENSOR;
      r.sensor_code = it.sensor_fault_code;
      r.next_state  = NS_END;
    end
    return r;
  endfunction

  function automatic item_t item_of(logic cmd, logic run, logic [15:0] spd, logic flame,
                                    logic en, logic wat, logic heat, logic valve,
                                    logic [7:0] sens);
    item_t it;
    it.cmd = cmd;
    it.fan_running = run;
    it.fan_speed = spd;
    it.flame_seen = flame;
    it.burn_enable = en;
    it.water_flow = wat;
    it.overheat_switch = heat;
    it.valve_fault = valve;
    it.sensor_fault_code = sens;
    return it;
  endfunction

  function automatic result_t res_of(logic [1:0] ns, logic [2:0] err, logic [7:0] code,
                                     logic off, logic [15:0] thr);
    result_t r;
    r.next_state = ns;
    r.error_kind = err;
    r.sensor_code = code;
    r.fan_force_off = off;
    r.blocked_threshold = thr;
    return r;
  endfunction

  function automatic drow_t item_row(item_t it, result_t res);
    drow_t d;
    d.is_cfg = 0;
    d.addr = '0;
    d.wdata = '0;
    d.it = it;
    d.res = res;
    return d;
  endfunction

  function automatic drow_t cfg_row(logic [2:0] addr, logic [15:0] val);
    drow_t d;
    d.is_cfg = 1;
    d.addr = addr;
    d.wdata = val;
    d.it = '0;
    d.res = '0;
    return d;
  endfunction

  function automatic item_t noise_item();
    logic [31:0] raw;
    item_t       it;
    raw = $urandom;
    it = raw[30:0];
    it.cmd = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic item_t good_tick(int unsigned fault_rate);
    item_t       it;
    int unsigned band;
    int          step;
    it = '0;
    it.cmd = CMD_TICK;
    it.fan_running = 1'b1;
    it.burn_enable = 1'b1;
    it.water_flow = 1'b1;
    band = cfg_now.speed_band;
    if (band > 3000) band = 3000;
    step = $urandom_range(0, band);
    if ($urandom_range(0, 29) == 0) walk_spd = $urandom_range(0, 65535);
    else if ($urandom_range(0, 1) == 1) walk_spd += step;
    else walk_spd -= step;
    if (walk_spd < 0) walk_spd = 0;
    if (walk_spd > 65535) walk_spd = 65535;
    it.fan_speed = 16'(walk_spd);
    if ($urandom_range(1, fault_rate) == 1) begin
      case ($urandom_range(0, 6))
        0: it.fan_running = 1'b0;
        1: it.flame_seen = 1'b1;
        2: it.burn_enable = 1'b0;
        3: it.water_flow = 1'b0;
        4: it.overheat_switch = 1'b1;
        5: it.valve_fault = 1'b1;
        default: it.sensor_fault_code = 8'($urandom_range(1, 255));
      endcase
    end
    return it;
  endfunction

  task automatic offer_tick(item_t it, bit typed, result_t res);
    result_t want;
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {2'b00, it.sensor_fault_code, it.valve_fault, it.overheat_switch,
                  it.water_flow, it.burn_enable, it.flame_seen, it.fan_speed,
                  it.fan_running};
    valid_held = 1;
    do @(posedge clk); while (!in_tready);
    want = purge_judge(it);
    verdict_q.push_back(typed ? res : want);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      valid_held = 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 0;
    end
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      CFG_MIN_PURGE:   cfg_now.min_purge = val;
      CFG_TIMEOUT:     cfg_now.timeout = val;
      CFG_RAMP:        cfg_now.ramp = val;
      CFG_SPEED_BAND:  cfg_now.speed_band = val;
      CFG_STABLE:      cfg_now.stable = val[7:0];
      CFG_FLAME_FAULT: cfg_now.flame_fault = val;
      CFG_BASE_SPEED:  cfg_now.base_speed = val;
      default:         cfg_now.blocked = val;
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    settle();
    write_reg(CFG_MIN_PURGE, c.min_purge);
    write_reg(CFG_TIMEOUT, c.timeout);
    write_reg(CFG_RAMP, c.ramp);
    write_reg(CFG_SPEED_BAND, c.speed_band);
    write_reg(CFG_STABLE, {8'd0, c.stable});
    write_reg(CFG_FLAME_FAULT, c.flame_fault);
    write_reg(CFG_BASE_SPEED, c.base_speed);
    write_reg(CFG_BLOCKED, c.blocked);
  endtask

  // receiver: stall pattern drawn at random from four modes
  always @(posedge clk) begin
    rcv_tick++;
    if (rcv_tick % 64 == 0) rcv_mode = $urandom_range(0, 3);
    case (rcv_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= (rcv_tick % 4 == 0);
      default: begin
        if (rcv_hold > 0) rcv_hold--;
        else if ($urandom_range(0, 7) == 0) rcv_hold = $urandom_range(3, 15);
        out_tready <= (rcv_hold == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen_count++;
      got.next_state        = out_tdata[1:0];
      got.error_kind        = out_tdata[4:2];
      got.sensor_code       = out_tdata[12:5];
      got.fan_force_off     = out_tdata[13];
      got.blocked_threshold = out_tdata[29:14];
      if (verdict_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("result %0d: no result expected, got tdata=%h", seen_count, out_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display("result %0d: expected ns=%0d err=%0d code=%0d off=%0d thr=%0d, %s",
                     seen_count, want.next_state, want.error_kind, want.sensor_code,
                     want.fan_force_off, want.blocked_threshold,
                     $sformatf("got ns=%0d err=%0d code=%0d off=%0d thr=%0d",
                               got.next_state, got.error_kind, got.sensor_code,
                               got.fan_force_off, got.blocked_threshold));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    drow_t rows[$];
    cfg_t  phase_cfg[NPHASE];
    int    phase_len[NPHASE];
    item_t it;
    int    p, n, sent, cap, kind, i;

    cfg_now = '{RST_MIN_PURGE, RST_TIMEOUT, RST_RAMP, RST_SPEED_BAND, RST_STABLE,
                RST_FLAME_FAULT, 16'd0, 16'd0};

    rows.push_back(item_row(item_of(CMD_ENTER, 0, 16'd0, 0, 0, 0, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd0, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'hFFFF, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 0, 16'd0, 0, 0, 1, 0, 0, 8'd0),
                            res_of(NS_IDLE, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd300, 0, 1, 0, 0, 0, 8'd0),
                            res_of(NS_IDLE, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd300, 0, 1, 1, 1, 0, 8'd0),
                            res_of(NS_END, ERR_HEAT, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd300, 0, 1, 1, 0, 1, 8'd0),
                            res_of(NS_END, ERR_HEAT, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd300, 0, 1, 1, 0, 0, 8'hFF),
                            res_of(NS_END, ERR_SENSOR, 8'hFF, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd300, 0, 0, 1, 1, 0, 8'h01),
                            res_of(NS_END, ERR_SENSOR, 8'h01, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd300, 1, 1, 1, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_ENTER, 1, 16'hFFFF, 1, 1, 1, 1, 1, 8'hFF),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    // zero ramp: threshold jumps straight to blocked speed
    rows.push_back(cfg_row(CFG_MIN_PURGE, 16'd0));
    rows.push_back(cfg_row(CFG_RAMP, 16'd0));
    rows.push_back(cfg_row(CFG_BASE_SPEED, 16'd7));
    rows.push_back(cfg_row(CFG_BLOCKED, 16'd1234));
    rows.push_back(item_row(item_of(CMD_ENTER, 0, 16'd0, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd5, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd1234)));
    // zero flame-fault count faults even without flame
    rows.push_back(cfg_row(CFG_FLAME_FAULT, 16'd0));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd5, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_END, ERR_FLAME, 8'd0, 0, 16'd1234)));
    rows.push_back(cfg_row(CFG_FLAME_FAULT, 16'd100));
    rows.push_back(cfg_row(CFG_TIMEOUT, 16'd0));
    rows.push_back(item_row(item_of(CMD_TICK, 0, 16'd5, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_END, ERR_STOPPED, 8'd0, 1, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd5, 1, 1, 1, 0, 0, 8'd0),
                            res_of(NS_STAY, ERR_NONE, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd5, 0, 1, 1, 0, 0, 8'd0),
                            res_of(NS_END, ERR_BLOCKED, 8'd0, 0, 16'd0)));
    rows.push_back(item_row(item_of(CMD_TICK, 1, 16'd5, 0, 1, 0, 0, 0, 8'd0),
                            res_of(NS_IDLE, ERR_BLOCKED, 8'd0, 0, 16'd0)));

    // min_purge, timeout, ramp, band, stable, flame_fault, base, blocked
    phase_cfg[0] = '{16'd10, 16'd60, 16'd20, 16'd200, 8'd5, 16'd4, 16'd1000, 16'd3000};
    phase_cfg[1] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0, 16'd1, 16'hFFFF, 16'd0};
    phase_cfg[2] = '{16'd5, 16'd40, 16'd1, 16'd50, 8'd2, 16'hFFFF, 16'd0, 16'hFFFF};
    phase_cfg[3] = '{16'd20, 16'hFFFF, 16'd30, 16'd0, 8'd8, 16'd10, 16'd5000, 16'd2000};
    phase_cfg[4] = '{16'hFFFF, 16'd30, 16'd600, 16'd100, 8'd255, 16'd2, 16'd0, 16'd0};
    phase_cfg[5] = '{16'd15, 16'd90, 16'd40, 16'd300, 8'd10, 16'd6, 16'd2000, 16'd40000};
    phase_cfg[6] = '{RST_MIN_PURGE, RST_TIMEOUT, RST_RAMP, RST_SPEED_BAND, RST_STABLE,
                     RST_FLAME_FAULT, 16'd0, 16'd0};
    phase_len = '{350, 150, 300, 300, 150, 350, 250};

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        settle();
        write_reg(rows[k].addr, rows[k].wdata);
      end else begin
        offer_tick(rows[k].it, 1, rows[k].res);
      end
    end

    for (p = 0; p < NPHASE; p++) begin
      load_cfg(phase_cfg[p]);
      sent = 0;
      while (sent < phase_len[p]) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          n = $urandom_range(1, 8);
          repeat (n) offer_tick(noise_item(), 0, '0);
          sent += n;
        end else begin
          cap = cfg_now.timeout + 10;
          if (cap > 200) cap = 200;
          n = $urandom_range(1, cap);
          it = noise_item();
          it.cmd = CMD_ENTER;
          offer_tick(it, 0, '0);
          walk_spd = $urandom_range(cfg_now.base_speed, cfg_now.blocked);
          for (i = 0; i < n; i++) begin
            it = good_tick(kind == 1 ? 6 : 60);
            if (kind == 2) it.flame_seen = ($urandom_range(0, 4) != 0);
            offer_tick(it, 0, '0);
          end
          sent += n + 1;
        end
      end
    end

    settle();
    if (bad_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
